// File: rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg: shared definitions for the ANSI text console
// Character codes, escape parser phases, register indexes, reset values and
// the small helper functions used by the console datapath.
// ----------------------------------------------------------------------------
package atc_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_NONE   = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_CSI    = 3'd2;
  localparam logic [2:0] PH_NUM1   = 3'd3;
  localparam logic [2:0] PH_NUM2   = 3'd4;
  localparam logic [2:0] PH_CHARSET = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_ATTR = 2'd2;

  // Reset values.
  localparam logic [5:0] RESET_ROWS = 6'd25;
  localparam logic [7:0] RESET_COLS = 8'd80;
  localparam logic [7:0] RESET_ATTR = 8'd7;

  // Control and sequence bytes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_U  = 8'h75;

  // Attribute bits.
  localparam logic [7:0] ATTR_BRIGHT = 8'h08;
  localparam logic [7:0] ATTR_BLINK  = 8'h80;

  localparam logic [15:0] NUM_MAX = 16'hFFFF;

  // ANSI colour number to attribute colour bits.
  function automatic logic [2:0] colour_map(input logic [2:0] idx);
    logic [2:0] res;
    case (idx)
      3'd0: res = 3'd0;
      3'd1: res = 3'd4;
      3'd2: res = 3'd2;
      3'd3: res = 3'd6;
      3'd4: res = 3'd1;
      3'd5: res = 3'd5;
      3'd6: res = 3'd3;
      default: res = 3'd7;
    endcase
    return res;
  endfunction

  // Decimal accumulate with saturation.
  function automatic logic [15:0] sat_acc(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, d};
    return (t > {4'b0, NUM_MAX}) ? NUM_MAX : t[15:0];
  endfunction

endpackage

// File: rtl/ansi_text_console_top.sv
// ----------------------------------------------------------------------------
// ansi_text_console_top: text-mode terminal with escape sequence parser
// Keeps a character/attribute screen store, a cursor and the current
// attribute, prints characters with wrap and scroll and interprets control
// codes and ESC / ESC[ sequences. A read word returns one screen cell.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-----------------------------------
//   item     | item_valid / item_stall    | kind, char_code, read_row, read_col
//   result   | result_valid / result_stall| read_char, read_attr, cursor_row,
//            |                            | cursor_col, current_attr,
//            |                            | cursor_cell, escape_active
//   config   | APB write/read             | rows_in_use, cols_in_use,
//            |                            | default_attr
//
// A word is taken, decoded in S_EXEC and then finished by a small
// sequencer that drives the single write port and single read port of the
// screen RAM. A cursor move or a printed character that does not scroll
// goes from S_EXEC straight to S_DONE, and a read passes through S_RDWAIT
// on the way, since it waits for the registered RAM data.
// Line clears and screen clears write one cell per cycle; a scroll
// copies each cell with a read state and a write state and then blanks the
// last row. After reset the RAM is swept once, writing every cell, before
// the first word is taken. item_stall is high whenever a word is in flight,
// and the result word is held until result_stall is low.
module ansi_text_console_top #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        kind,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attr,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [7:0]  current_attr,
  output logic [11:0] cursor_cell,
  output logic        escape_active,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NRW   = RW + 1;
  localparam int NCW   = CW + 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TSW   = $clog2(TAB_STOP + 1);
  localparam int REPW  = (NRW > TSW) ? NRW : TSW;
  localparam int CLW   = RW + NCW + 1;

  localparam logic [15:0] RESET_CELL = {atc_pkg::RESET_ATTR, atc_pkg::CH_SPACE};

  typedef enum logic [11:0] {
    S_INIT   = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_EXEC   = 12'b0000_0000_0100,
    S_RDWAIT = 12'b0000_0000_1000,
    S_TABMOD = 12'b0000_0001_0000,
    S_NEXT   = 12'b0000_0010_0000,
    S_PRINT  = 12'b0000_0100_0000,
    S_LF     = 12'b0000_1000_0000,
    S_FILL   = 12'b0001_0000_0000,
    S_SCR_RD = 12'b0010_0000_0000,
    S_SCR_WR = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  // Registers.
  state_t            state, state_next;
  logic [5:0]        rows_reg;
  logic [7:0]        cols_reg;
  logic [7:0]        dattr_reg;
  logic [RW-1:0]     cur_row, row_next;
  logic [CW-1:0]     cur_col, col_next;
  logic [7:0]        text_attr, attr_next;
  logic [2:0]        phase, phase_next;
  logic [15:0]       num1, num1_next;
  logic [15:0]       num2, num2_next;
  logic [REPW-1:0]   rep, rep_next;
  logic              loop_tab, loop_tab_next;
  logic [RW-1:0]     wr, wr_next;
  logic [CW-1:0]     wc, wc_next;
  logic [CW-1:0]     fill_col0, fill_col0_next;
  logic [RW-1:0]     fill_row_last, fill_row_last_next;
  logic [15:0]       fill_val, fill_val_next;
  logic [CW-1:0]     tmod, tmod_next;
  logic [AW-1:0]     init_addr, init_addr_next;
  logic [7:0]        rd_char, rd_char_next;
  logic [7:0]        rd_attr, rd_attr_next;
  logic              item_kind;
  logic [7:0]        item_char;
  logic [4:0]        item_row;
  logic [6:0]        item_col;

  // RAM port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [15:0]       ram_rdata;

  // Screen geometry and clamped cursor.
  logic [NRW-1:0]    nrows;
  logic [NCW-1:0]    ncols;
  logic [RW-1:0]     nr_m1;
  logic [CW-1:0]     nc_m1;
  logic [RW-1:0]     crow;
  logic [CW-1:0]     ccol;
  logic              is_digit;
  logic [15:0]       seq_x, seq_y;
  logic              rd_in_range;
  logic [AW-1:0]     rd_addr;
  logic              cfg_wr;
  logic [CLW-1:0]    cell_full;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  atc_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Size registers out of range act as the nearest legal size.
  always_comb begin
    if (rows_reg == 6'd0) begin
      nrows = NRW'(1);
    end else if ({1'b0, rows_reg} > 7'(MAX_ROWS)) begin
      nrows = NRW'(MAX_ROWS);
    end else begin
      nrows = NRW'(rows_reg);
    end
    if (cols_reg == 8'd0) begin
      ncols = NCW'(1);
    end else if ({1'b0, cols_reg} > 9'(MAX_COLS)) begin
      ncols = NCW'(MAX_COLS);
    end else begin
      ncols = NCW'(cols_reg);
    end
  end

  assign nr_m1 = RW'(nrows - NRW'(1));
  assign nc_m1 = CW'(ncols - NCW'(1));
  // The cursor is pulled back into the screen while idle and before every
  // word is handled, which covers a size register that shrank.
  assign crow = ({1'b0, cur_row} >= nrows) ? nr_m1 : cur_row;
  assign ccol = ({1'b0, cur_col} >= ncols) ? nc_m1 : cur_col;

  assign is_digit = (item_char inside {[8'h30:8'h39]});

  // Read address of a read word; cells outside the store read as zero.
  assign rd_in_range = (32'(item_row) < MAX_ROWS) && (32'(item_col) < MAX_COLS);
  assign rd_addr     = AW'(32'(item_row) * MAX_COLS + 32'(item_col));

  // Sequence arguments as they stand when the final byte arrives.
  always_comb begin
    seq_x = 16'd1;
    seq_y = 16'd1;
    case (phase)
      atc_pkg::PH_CSI: begin
        if (item_char inside {atc_pkg::CH_LC_S, atc_pkg::CH_LC_U, atc_pkg::CH_LC_R,
                              atc_pkg::CH_LC_M}) begin
          seq_x = 16'd0;
          seq_y = 16'd0;
        end
      end
      atc_pkg::PH_NUM1: begin
        seq_x = num1;
      end
      atc_pkg::PH_NUM2: begin
        seq_x = num1;
        seq_y = num2;
      end
      default: begin
        seq_x = 16'd1;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    logic          go_scroll;
    logic          go_fill;
    logic          run_seq;
    logic          do_print;
    logic [7:0]    print_ch;
    logic [RW-1:0] f_row;
    logic [CW-1:0] f_col;
    logic [RW-1:0] f_last;
    logic [15:0]   f_val;
    logic [16:0]   sum;
    logic [15:0]   xm30;
    logic [15:0]   xm40;
    logic [7:0]    a;

    go_scroll = 1'b0;
    go_fill   = 1'b0;
    run_seq   = 1'b0;
    do_print  = 1'b0;
    print_ch  = atc_pkg::CH_SPACE;
    f_row     = crow;
    f_col     = ccol;
    f_last    = crow;
    f_val     = {text_attr, atc_pkg::CH_SPACE};
    sum       = 17'd0;
    xm30      = seq_x - 16'd30;
    xm40      = seq_x - 16'd40;
    a         = text_attr;

    state_next         = state;
    row_next           = cur_row;
    col_next           = cur_col;
    attr_next          = text_attr;
    phase_next         = phase;
    num1_next          = num1;
    num2_next          = num2;
    rep_next           = rep;
    loop_tab_next      = loop_tab;
    wr_next            = wr;
    wc_next            = wc;
    fill_col0_next     = fill_col0;
    fill_row_last_next = fill_row_last;
    fill_val_next      = fill_val;
    tmod_next          = tmod;
    init_addr_next     = init_addr;
    rd_char_next       = rd_char;
    rd_attr_next       = rd_attr;

    ram_we    = 1'b0;
    ram_waddr = cell_addr(wr, wc);
    ram_wdata = fill_val;
    ram_raddr = cell_addr(wr, wc);

    case (state)
      S_INIT: begin
        ram_we         = 1'b1;
        ram_waddr      = init_addr;
        ram_wdata      = RESET_CELL;
        init_addr_next = init_addr + AW'(1);
        if (init_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        // A size write clamps the cursor for good, even if it grows again.
        row_next = crow;
        col_next = ccol;
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        row_next     = crow;
        col_next     = ccol;
        rd_char_next = 8'd0;
        rd_attr_next = 8'd0;
        rep_next     = '0;
        state_next   = S_DONE;
        if (item_kind) begin
          ram_raddr  = rd_addr;
          state_next = S_RDWAIT;
        end else if (phase != atc_pkg::PH_NONE) begin
          phase_next = atc_pkg::PH_NONE;
          case (phase)
            atc_pkg::PH_ESC: begin
              case (item_char)
                atc_pkg::CH_LBRK: phase_next = atc_pkg::PH_CSI;
                atc_pkg::CH_LPAR: phase_next = atc_pkg::PH_CHARSET;
                atc_pkg::CH_P: begin
                  if (crow != nr_m1) row_next = crow + RW'(1);
                end
                atc_pkg::CH_K: begin
                  if (ccol != '0) col_next = ccol - CW'(1);
                end
                atc_pkg::CH_H: begin
                  if (crow != '0) row_next = crow - RW'(1);
                end
                atc_pkg::CH_D: go_scroll = 1'b1;
                atc_pkg::CH_G: begin
                  row_next = '0;
                  col_next = '0;
                end
                atc_pkg::CH_LC_C: begin
                  row_next  = '0;
                  col_next  = '0;
                  attr_next = dattr_reg;
                end
                default: phase_next = atc_pkg::PH_NONE;
              endcase
            end
            atc_pkg::PH_CSI: begin
              if (item_char == atc_pkg::CH_QUEST) begin
                phase_next = atc_pkg::PH_NUM1;
              end else if (is_digit) begin
                num1_next  = {12'd0, item_char[3:0]};
                phase_next = atc_pkg::PH_NUM1;
              end else begin
                run_seq = 1'b1;
              end
            end
            atc_pkg::PH_NUM1: begin
              if (is_digit) begin
                num1_next  = atc_pkg::sat_acc(num1, item_char[3:0]);
                phase_next = atc_pkg::PH_NUM1;
              end else if (item_char == atc_pkg::CH_SEMI) begin
                num2_next  = 16'd0;
                phase_next = atc_pkg::PH_NUM2;
              end else begin
                run_seq = 1'b1;
              end
            end
            atc_pkg::PH_NUM2: begin
              if (is_digit) begin
                num2_next  = atc_pkg::sat_acc(num2, item_char[3:0]);
                phase_next = atc_pkg::PH_NUM2;
              end else begin
                run_seq = 1'b1;
              end
            end
            default: phase_next = atc_pkg::PH_NONE;
          endcase
        end else begin
          case (item_char)
            atc_pkg::CH_NUL: begin
              rep_next = '0;
            end
            atc_pkg::CH_LF: begin
              // Blank the rest of the line, then one line feed.
              go_fill       = 1'b1;
              col_next      = '0;
              rep_next      = REPW'(1);
              loop_tab_next = 1'b0;
            end
            atc_pkg::CH_CR: col_next = '0;
            atc_pkg::CH_TAB: begin
              tmod_next  = ccol;
              state_next = S_TABMOD;
            end
            atc_pkg::CH_BS: begin
              if (ccol != '0) begin
                col_next  = ccol - CW'(1);
                ram_we    = 1'b1;
                ram_waddr = cell_addr(crow, ccol - CW'(1));
                ram_wdata = {text_attr, atc_pkg::CH_SPACE};
              end
            end
            atc_pkg::CH_FF: begin
              go_fill  = 1'b1;
              f_row    = '0;
              f_col    = '0;
              f_last   = nr_m1;
              f_val    = {dattr_reg, atc_pkg::CH_SPACE};
              row_next = '0;
              col_next = '0;
            end
            atc_pkg::CH_ESC: phase_next = atc_pkg::PH_ESC;
            default: begin
              do_print = 1'b1;
              print_ch = item_char;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        if (rd_in_range) begin
          rd_char_next = ram_rdata[7:0];
          rd_attr_next = ram_rdata[15:8];
        end
        state_next = S_DONE;
      end

      S_TABMOD: begin
        // Column modulo the tab stop, one subtraction per cycle.
        if (32'(tmod) >= TAB_STOP) begin
          tmod_next = tmod - CW'(TAB_STOP);
        end else begin
          rep_next      = REPW'(TAB_STOP) - REPW'(tmod);
          loop_tab_next = 1'b1;
          state_next    = S_NEXT;
        end
      end

      S_NEXT: begin
        if (rep != '0) begin
          state_next = loop_tab ? S_PRINT : S_LF;
        end else begin
          state_next = S_DONE;
        end
      end

      S_PRINT: begin
        rep_next = rep - REPW'(1);
        do_print = 1'b1;
      end

      S_LF: begin
        rep_next   = rep - REPW'(1);
        state_next = S_NEXT;
        if (crow == nr_m1) begin
          go_scroll = 1'b1;
        end else begin
          row_next = crow + RW'(1);
        end
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(wr, wc);
        ram_wdata = fill_val;
        if (wc == nc_m1) begin
          if (wr == fill_row_last) begin
            state_next = S_NEXT;
          end else begin
            wr_next = wr + RW'(1);
            wc_next = fill_col0;
          end
        end else begin
          wc_next = wc + CW'(1);
        end
      end

      S_SCR_RD: begin
        ram_raddr  = cell_addr(wr, wc);
        state_next = S_SCR_WR;
      end

      S_SCR_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = cell_addr(wr - RW'(1), wc);
        ram_wdata  = ram_rdata;
        state_next = S_SCR_RD;
        if (wc == nc_m1) begin
          if (wr == nr_m1) begin
            go_fill = 1'b1;
            f_row   = nr_m1;
            f_col   = '0;
            f_last  = nr_m1;
          end else begin
            wr_next = wr + RW'(1);
            wc_next = '0;
          end
        end else begin
          wc_next = wc + CW'(1);
        end
      end

      S_DONE: begin
        if (!result_stall) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Print one cell at the cursor and advance with wrap and scroll.
    if (do_print) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(crow, ccol);
      ram_wdata = {text_attr, print_ch};
      if (state == S_PRINT) begin
        state_next = S_NEXT;
      end
      if (ccol != nc_m1) begin
        col_next = ccol + CW'(1);
      end else begin
        col_next = '0;
        if (crow == nr_m1) begin
          go_scroll = 1'b1;
        end else begin
          row_next = crow + RW'(1);
        end
      end
    end

    // Final byte of an ESC[ sequence.
    if (run_seq) begin
      case (item_char)
        atc_pkg::CH_H: begin
          if (seq_x == 16'd0) row_next = '0;
          else if (seq_x > 16'(nrows)) row_next = nr_m1;
          else row_next = RW'(seq_x - 16'd1);
          if (seq_y == 16'd0) col_next = '0;
          else if (seq_y > 16'(ncols)) col_next = nc_m1;
          else col_next = CW'(seq_y - 16'd1);
        end
        atc_pkg::CH_J: begin
          if (seq_x != 16'd1) begin
            go_fill  = 1'b1;
            f_row    = '0;
            f_col    = '0;
            f_last   = nr_m1;
            f_val    = {dattr_reg, atc_pkg::CH_SPACE};
            row_next = '0;
            col_next = '0;
          end
        end
        atc_pkg::CH_K: go_fill = 1'b1;
        atc_pkg::CH_LC_M: begin
          if (seq_x inside {[16'd30:16'd37]}) begin
            a = {text_attr[7:3], atc_pkg::colour_map(xm30[2:0])};
          end else if (seq_x inside {[16'd40:16'd47]}) begin
            a = {text_attr[7], atc_pkg::colour_map(xm40[2:0]), text_attr[3:0]};
          end else if (seq_x == 16'd1) begin
            a = text_attr | atc_pkg::ATTR_BRIGHT;
          end else if (seq_x == 16'd2) begin
            a = text_attr & ~atc_pkg::ATTR_BRIGHT;
          end else if (seq_x == 16'd5) begin
            a = text_attr | atc_pkg::ATTR_BLINK;
          end else if (seq_x == 16'd6) begin
            a = text_attr & ~atc_pkg::ATTR_BLINK;
          end else if (seq_x == 16'd7) begin
            a = {text_attr[3:0], text_attr[7:4]};
          end else if (seq_x == 16'd8) begin
            a = {text_attr[7:4], text_attr[7:4]};
          end else begin
            a = dattr_reg;
          end
          attr_next = a;
        end
        atc_pkg::CH_A: begin
          if (seq_x >= 16'(crow)) row_next = '0;
          else row_next = crow - RW'(seq_x);
        end
        atc_pkg::CH_B: begin
          sum = {1'b0, seq_x} + 17'(crow);
          if (sum >= 17'(nrows)) row_next = nr_m1;
          else row_next = RW'(sum);
        end
        atc_pkg::CH_C: begin
          sum = {1'b0, seq_x} + 17'(ccol);
          if (sum >= 17'(ncols)) col_next = nc_m1;
          else col_next = CW'(sum);
        end
        atc_pkg::CH_D: begin
          if (seq_x >= 16'(ccol)) col_next = '0;
          else col_next = ccol - CW'(seq_x);
        end
        atc_pkg::CH_L: begin
          // Line insert is a run of line feeds, at most one screen's worth.
          rep_next      = (seq_x < 16'(nrows)) ? REPW'(seq_x) : REPW'(nrows);
          loop_tab_next = 1'b0;
          state_next    = S_NEXT;
        end
        default: rep_next = '0;
      endcase
    end

    // Scroll: copy rows up, then blank the last row. The cursor stays put.
    if (go_scroll) begin
      if (nr_m1 == '0) begin
        go_fill = 1'b1;
        f_row   = nr_m1;
        f_col   = '0;
        f_last  = nr_m1;
        f_val   = {text_attr, atc_pkg::CH_SPACE};
      end else begin
        wr_next    = RW'(1);
        wc_next    = '0;
        state_next = S_SCR_RD;
      end
    end

    if (go_fill) begin
      wr_next            = f_row;
      wc_next            = f_col;
      fill_col0_next     = f_col;
      fill_row_last_next = f_last;
      fill_val_next      = f_val;
      state_next         = S_FILL;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_addr <= '0;
      rows_reg  <= atc_pkg::RESET_ROWS;
      cols_reg  <= atc_pkg::RESET_COLS;
      dattr_reg <= atc_pkg::RESET_ATTR;
      cur_row   <= '0;
      cur_col   <= '0;
      text_attr <= atc_pkg::RESET_ATTR;
      phase     <= atc_pkg::PH_NONE;
      num1      <= '0;
      num2      <= '0;
      rep       <= '0;
      loop_tab  <= 1'b0;
    end else begin
      state     <= state_next;
      init_addr <= init_addr_next;
      cur_row   <= row_next;
      cur_col   <= col_next;
      text_attr <= attr_next;
      phase     <= phase_next;
      num1      <= num1_next;
      num2      <= num2_next;
      rep       <= rep_next;
      loop_tab  <= loop_tab_next;
      if (cfg_wr) begin
        case (paddr[3:2])
          atc_pkg::REG_ROWS: rows_reg  <= pwdata[5:0];
          atc_pkg::REG_COLS: cols_reg  <= pwdata[7:0];
          atc_pkg::REG_ATTR: dattr_reg <= pwdata[7:0];
          default: rows_reg <= rows_reg;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wr            <= wr_next;
    wc            <= wc_next;
    fill_col0     <= fill_col0_next;
    fill_row_last <= fill_row_last_next;
    fill_val      <= fill_val_next;
    tmod          <= tmod_next;
    rd_char       <= rd_char_next;
    rd_attr       <= rd_attr_next;
    if (state == S_IDLE && item_valid) begin
      item_kind <= kind;
      item_char <= char_code;
      item_row  <= read_row;
      item_col  <= read_col;
    end
  end

  always_comb begin
    case (paddr[3:2])
      atc_pkg::REG_ROWS: prdata = {26'd0, rows_reg};
      atc_pkg::REG_COLS: prdata = {24'd0, cols_reg};
      atc_pkg::REG_ATTR: prdata = {24'd0, dattr_reg};
      default:           prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // Outputs.
  assign item_stall    = (state != S_IDLE);
  assign result_valid  = (state == S_DONE);
  assign read_char     = rd_char;
  assign read_attr     = rd_attr;
  assign cursor_row    = 5'(cur_row);
  assign cursor_col    = 7'(cur_col);
  assign current_attr  = text_attr;
  assign cell_full     = CLW'(cur_row) * CLW'(ncols) + CLW'(cur_col);
  assign cursor_cell   = 12'(cell_full);
  assign escape_active = (phase != atc_pkg::PH_NONE);

  // The screen store is never written while waiting for or holding a word.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !ram_we)
    else $error("screen write outside of word processing");

  // A finished word always shows a cursor inside the screen.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, cur_row} < nrows && {1'b0, cur_col} < ncols))
    else $error("cursor outside the screen at result");

  // A word is never finished in the cycle right after it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !result_valid)
    else $error("result appeared without processing");

endmodule

// File: rtl/atc_ram.sv
// ----------------------------------------------------------------------------
// atc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module atc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ANSI text console
// Feeds printed bytes, escape sequences and cell reads through the word
// channel and compares every result word with a behavioral model of the
// console. The model holds its own screen store, cursor and parser. The run
// steps through several screen sizes and attributes, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STORE_COLS = 128;
  localparam int STORE_ROWS = 32;
  localparam int TAB_WIDTH = 8;
  // Worst case: a line insert of a full screen at the largest size does 32
  // full scrolls, so the limit is several times what those take.
  localparam int WATCHDOG_LIMIT = 1200000;

  // Bytes the package does not name.
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_LC_H = 8'h68;
  localparam logic [7:0] CH_LC_L = 8'h6C;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
    logic [4:0] row;
    logic [6:0] col;
  } console_word_t;

  typedef struct packed {
    logic [7:0]  rd_char;
    logic [7:0]  rd_attr;
    logic [4:0]  row;
    logic [6:0]  col;
    logic [7:0]  attr;
    logic [11:0] cell_pos;
    logic        esc;
  } console_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        kind = 1'b0;
  logic [7:0]  char_code = '0;
  logic [4:0]  read_row = '0;
  logic [6:0]  read_col = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  read_char;
  logic [7:0]  read_attr;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [7:0]  current_attr;
  logic [11:0] cursor_cell;
  logic        escape_active;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ansi_text_console_top dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .char_code(char_code), .read_row(read_row), .read_col(read_col),
    .result_valid(result_valid), .result_stall(result_stall),
    .read_char(read_char), .read_attr(read_attr),
    .cursor_row(cursor_row), .cursor_col(cursor_col),
    .current_attr(current_attr), .cursor_cell(cursor_cell),
    .escape_active(escape_active),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Words waiting to be sent and screen views waiting to come back.
  console_word_t pending_words[$];
  console_view_t expected_views[$];
  int errors = 0;
  bit quiet = 1'b0;  // set for the last part of the run: no idling at all

  // --------------------------------------------------------------------------
  // Console model: configuration, cursor, attribute, parser and screen store.
  // --------------------------------------------------------------------------
  int unsigned cfg_rows = atc_pkg::RESET_ROWS;
  int unsigned cfg_cols = atc_pkg::RESET_COLS;
  int unsigned cfg_attr = atc_pkg::RESET_ATTR;
  int unsigned crow, ccol, cattr, phase, num_first, num_second;
  logic [15:0] screen [0:STORE_ROWS*STORE_COLS-1];

  function automatic int unsigned rows_eff();
    if (cfg_rows == 0) return 1;
    return (cfg_rows > STORE_ROWS) ? STORE_ROWS : cfg_rows;
  endfunction

  function automatic int unsigned cols_eff();
    if (cfg_cols == 0) return 1;
    return (cfg_cols > STORE_COLS) ? STORE_COLS : cfg_cols;
  endfunction

  function automatic logic [2:0] ansi_colour(input int unsigned idx);
    logic [2:0] bits;
    bits = {idx[0], idx[1], idx[2]};  // the ANSI order is the bit reverse
    return bits;
  endfunction

  task automatic clamp_cursor();
    if (crow >= rows_eff()) crow = rows_eff() - 1;
    if (ccol >= cols_eff()) ccol = cols_eff() - 1;
  endtask

  task automatic put(input int unsigned r, input int unsigned c,
                     input int unsigned ch, input int unsigned a);
    screen[r*STORE_COLS + c] = {a[7:0], ch[7:0]};
  endtask

  task automatic scroll();
    for (int unsigned r = 1; r < rows_eff(); r++)
      for (int unsigned c = 0; c < cols_eff(); c++)
        screen[(r-1)*STORE_COLS + c] = screen[r*STORE_COLS + c];
    for (int unsigned c = 0; c < cols_eff(); c++)
      put(rows_eff() - 1, c, atc_pkg::CH_SPACE, cattr);
  endtask

  task automatic next_line();
    crow++;
    if (crow >= rows_eff()) begin
      scroll();
      crow = rows_eff() - 1;
    end
  endtask

  task automatic blank_rest();
    for (int unsigned c = ccol; c < cols_eff(); c++) put(crow, c, atc_pkg::CH_SPACE, cattr);
  endtask

  task automatic wipe_screen();
    for (int unsigned r = 0; r < rows_eff(); r++)
      for (int unsigned c = 0; c < cols_eff(); c++) put(r, c, atc_pkg::CH_SPACE, cfg_attr);
    crow = 0;
    ccol = 0;
  endtask

  task automatic print_byte(input int unsigned ch);
    put(crow, ccol, ch, cattr);
    if (ccol + 1 < cols_eff()) begin
      ccol++;
    end else begin
      ccol = 0;
      next_line();
    end
  endtask

  function automatic int unsigned add_digit(input int unsigned v, input int unsigned d);
    int unsigned t;
    t = v * 10 + d;
    return (t > 65535) ? 65535 : t;
  endfunction

  // Final byte of an ESC[ sequence with its two parameters.
  task automatic do_final(input int unsigned x, input int unsigned y, input logic [7:0] ch);
    int unsigned a, n;
    a = cattr;
    case (ch)
      atc_pkg::CH_H: begin
        if (x < 1) x = 1;
        if (x > rows_eff()) x = rows_eff();
        if (y < 1) y = 1;
        if (y > cols_eff()) y = cols_eff();
        crow = x - 1;
        ccol = y - 1;
      end
      atc_pkg::CH_J: if (x != 1) wipe_screen();
      atc_pkg::CH_K: blank_rest();
      atc_pkg::CH_LC_M: begin
        if (x >= 30 && x <= 37) a = ansi_colour(x - 30) + (a & 8'hF8);
        else if (x >= 40 && x <= 47) a = (ansi_colour(x - 40) << 4) + (a & 8'h8F);
        else if (x == 1) a = a | atc_pkg::ATTR_BRIGHT;
        else if (x == 2) a = a & ~atc_pkg::ATTR_BRIGHT;
        else if (x == 5) a = a | atc_pkg::ATTR_BLINK;
        else if (x == 6) a = a & ~atc_pkg::ATTR_BLINK;
        else if (x == 7) a = ((a & 8'hF0) >> 4) + ((a & 8'h0F) << 4);
        else if (x == 8) a = ((a & 8'hF0) >> 4) + (a & 8'hF0);
        else a = cfg_attr;
        cattr = a & 8'hFF;
      end
      atc_pkg::CH_A: crow = (x >= crow) ? 0 : crow - x;
      atc_pkg::CH_B: crow = (crow + x >= rows_eff()) ? rows_eff() - 1 : crow + x;
      atc_pkg::CH_C: ccol = (ccol + x >= cols_eff()) ? cols_eff() - 1 : ccol + x;
      atc_pkg::CH_D: ccol = (x >= ccol) ? 0 : ccol - x;
      atc_pkg::CH_L: begin
        n = (x < rows_eff()) ? x : rows_eff();
        for (int unsigned i = 0; i < n; i++) next_line();
      end
      default: ;
    endcase
  endtask

  // Byte following a lone ESC.
  task automatic do_escape(input logic [7:0] ch);
    phase = atc_pkg::PH_NONE;
    case (ch)
      atc_pkg::CH_LBRK: phase = atc_pkg::PH_CSI;
      atc_pkg::CH_LPAR: phase = atc_pkg::PH_CHARSET;
      atc_pkg::CH_P: if (crow + 1 < rows_eff()) crow++;
      atc_pkg::CH_K: if (ccol > 0) ccol--;
      atc_pkg::CH_H: if (crow > 0) crow--;
      atc_pkg::CH_D: scroll();
      atc_pkg::CH_G: begin
        crow = 0;
        ccol = 0;
      end
      atc_pkg::CH_LC_C: begin
        crow = 0;
        ccol = 0;
        cattr = cfg_attr;
      end
      default: ;
    endcase
  endtask

  task automatic parse(input logic [7:0] ch);
    bit digit;
    digit = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT0 + 9);
    case (phase)
      atc_pkg::PH_ESC: do_escape(ch);
      atc_pkg::PH_CSI: begin
        phase = atc_pkg::PH_NONE;
        if (ch == atc_pkg::CH_QUEST) begin
          phase = atc_pkg::PH_NUM1;
        end else if (digit) begin
          num_first = ch - CH_DIGIT0;
          phase = atc_pkg::PH_NUM1;
        end else if (ch == atc_pkg::CH_LC_S || ch == atc_pkg::CH_LC_U ||
                     ch == atc_pkg::CH_LC_R || ch == atc_pkg::CH_LC_M) begin
          do_final(0, 0, ch);
        end else begin
          do_final(1, 1, ch);
        end
      end
      atc_pkg::PH_NUM1: begin
        if (digit) begin
          num_first = add_digit(num_first, ch - CH_DIGIT0);
        end else if (ch == atc_pkg::CH_SEMI) begin
          num_second = 0;
          phase = atc_pkg::PH_NUM2;
        end else begin
          phase = atc_pkg::PH_NONE;
          do_final(num_first, 1, ch);
        end
      end
      atc_pkg::PH_NUM2: begin
        if (digit) begin
          num_second = add_digit(num_second, ch - CH_DIGIT0);
        end else begin
          phase = atc_pkg::PH_NONE;
          do_final(num_first, num_second, ch);
        end
      end
      default: phase = atc_pkg::PH_NONE;  // the byte after ESC( is dropped
    endcase
  endtask

  task automatic control_or_print(input logic [7:0] ch);
    int unsigned n;
    case (ch)
      atc_pkg::CH_NUL: ;
      atc_pkg::CH_LF: begin
        blank_rest();
        ccol = 0;
        next_line();
      end
      atc_pkg::CH_CR: ccol = 0;
      atc_pkg::CH_TAB: begin
        n = TAB_WIDTH - (ccol % TAB_WIDTH);
        for (int unsigned i = 0; i < n; i++) print_byte(atc_pkg::CH_SPACE);
      end
      atc_pkg::CH_BS: if (ccol != 0) begin
        ccol--;
        put(crow, ccol, atc_pkg::CH_SPACE, cattr);
      end
      atc_pkg::CH_FF: wipe_screen();
      atc_pkg::CH_ESC: phase = atc_pkg::PH_ESC;
      default: print_byte(ch);
    endcase
  endtask

  // Applies one accepted word to the model and queues the view it should give.
  task automatic console_apply(input console_word_t w);
    console_view_t v;
    logic [15:0] stored;
    int unsigned pos;
    v = '0;
    clamp_cursor();
    if (w.kind) begin
      stored = screen[w.row*STORE_COLS + w.col];
      v.rd_char = stored[7:0];
      v.rd_attr = stored[15:8];
    end else if (phase != atc_pkg::PH_NONE) begin
      parse(w.code);
    end else begin
      control_or_print(w.code);
    end
    pos = crow * cols_eff() + ccol;
    v.row = crow[4:0];
    v.col = ccol[6:0];
    v.attr = cattr[7:0];
    v.cell_pos = pos[11:0];
    v.esc = (phase != atc_pkg::PH_NONE);
    expected_views.push_back(v);
  endtask

  task automatic console_reset();
    crow = 0;
    ccol = 0;
    cattr = cfg_attr;
    phase = atc_pkg::PH_NONE;
    num_first = 0;
    num_second = 0;
    for (int i = 0; i < STORE_ROWS*STORE_COLS; i++)
      screen[i] = {cfg_attr[7:0], atc_pkg::CH_SPACE};
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] ch);
    console_word_t w;
    w.kind = 1'b0;
    w.code = ch;
    w.row = 5'($urandom);  // don't-care fields still get random values
    w.col = 7'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic send_read(input logic [4:0] r, input logic [6:0] c);
    console_word_t w;
    w.kind = 1'b1;
    w.code = 8'($urandom);
    w.row = r;
    w.col = c;
    pending_words.push_back(w);
  endtask

  task automatic send_number(input int unsigned value);
    string s;
    s = $sformatf("%0d", value);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // ESC [ first ; second final, with either number left out when negative.
  task automatic send_csi(input int first, input int second, input logic [7:0] fin);
    send_byte(atc_pkg::CH_ESC);
    send_byte(atc_pkg::CH_LBRK);
    if (first >= 0) send_number(first);
    if (second >= 0) begin
      send_byte(atc_pkg::CH_SEMI);
      send_number(second);
    end
    send_byte(fin);
  endtask

  task automatic send_random_sequence();
    logic [7:0] finals[17];
    logic [7:0] fin;
    int first, second;
    finals = '{atc_pkg::CH_H, atc_pkg::CH_J, atc_pkg::CH_K, atc_pkg::CH_LC_M,
               atc_pkg::CH_A, atc_pkg::CH_B, atc_pkg::CH_C, atc_pkg::CH_D,
               atc_pkg::CH_L, atc_pkg::CH_LC_S, atc_pkg::CH_LC_U, atc_pkg::CH_LC_R,
               CH_LC_H, CH_LC_L, CH_M, CH_AT, atc_pkg::CH_P};
    fin = ($urandom_range(0, 9) == 0) ? 8'($urandom) : finals[$urandom_range(0, 16)];
    case ($urandom_range(0, 5))
      0: first = -1;
      1: first = $urandom_range(60000, 99999);  // saturating parameter
      default: first = $urandom_range(0, 40);
    endcase
    if (fin == atc_pkg::CH_LC_M && $urandom_range(0, 1)) first = $urandom_range(0, 47);
    if (fin == atc_pkg::CH_L) first = $urandom_range(0, 4);  // keeps line inserts short
    second = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 140) : -1;
    if (first < 0 && second >= 0) first = 0;
    if ($urandom_range(0, 7) == 0) begin
      // ESC[? keeps the old first number and keeps adding digits to it.
      send_byte(atc_pkg::CH_ESC);
      send_byte(atc_pkg::CH_LBRK);
      send_byte(atc_pkg::CH_QUEST);
      if (first > 0) send_number(first);
      send_byte(fin);
    end else if ($urandom_range(0, 15) == 0) begin
      // Broken sequence: a stray byte where a digit or final should be.
      send_byte(atc_pkg::CH_ESC);
      send_byte(atc_pkg::CH_LBRK);
      send_byte(8'($urandom));
    end else begin
      send_csi(first, second, fin);
    end
  endtask

  task automatic send_random_escape();
    logic [7:0] picks[9];
    logic [7:0] ch;
    picks = '{atc_pkg::CH_P, atc_pkg::CH_K, atc_pkg::CH_H, atc_pkg::CH_D, atc_pkg::CH_G,
              atc_pkg::CH_LC_C, atc_pkg::CH_LPAR, CH_M, CH_TILDE};
    ch = ($urandom_range(0, 5) == 0) ? 8'($urandom) : picks[$urandom_range(0, 8)];
    send_byte(atc_pkg::CH_ESC);
    send_byte(ch);
    if (ch == atc_pkg::CH_LPAR) send_byte(8'($urandom));
  endtask

  task automatic send_random_words(input int count, input bit scroll_light);
    logic [7:0] controls[7];
    int sel;
    controls = '{atc_pkg::CH_NUL, atc_pkg::CH_LF, atc_pkg::CH_CR, atc_pkg::CH_TAB,
                 atc_pkg::CH_BS, atc_pkg::CH_FF, atc_pkg::CH_ESC};
    while (count > 0) begin
      sel = $urandom_range(0, 99);
      count--;
      if (sel < 45) begin
        send_byte(8'($urandom_range(32, 126)));
      end else if (sel < 55) begin
        if (scroll_light && $urandom_range(0, 3) != 0) send_byte(atc_pkg::CH_CR);
        else send_byte(controls[$urandom_range(0, 6)]);
      end else if (sel < 75) begin
        send_random_sequence();
      end else if (sel < 82) begin
        send_random_escape();
      end else if (sel < 95) begin
        send_read(5'($urandom), 7'($urandom));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic send_directed();
    send_byte(8'h41);
    send_byte(8'hFF);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_byte(atc_pkg::CH_TAB);
    send_byte(atc_pkg::CH_BS);
    send_byte(atc_pkg::CH_NUL);
    send_byte(atc_pkg::CH_LF);
    send_byte(atc_pkg::CH_CR);
    send_csi(99999, -1, atc_pkg::CH_C);      // saturated move to the right edge
    send_csi(31, -1, atc_pkg::CH_LC_M);
    send_csi(7, -1, atc_pkg::CH_LC_M);
    send_csi(5, 200, atc_pkg::CH_H);         // column clamped to the last one
    send_read(5'd31, 7'd127);
    send_byte(atc_pkg::CH_ESC);
    send_byte(atc_pkg::CH_LPAR);
    send_byte(atc_pkg::CH_LF);               // dropped after ESC(
    send_byte(atc_pkg::CH_FF);
  endtask

  // --------------------------------------------------------------------------
  // Word driver: sends pending words, with random idle bursts.
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) console_apply('{kind, char_code, read_row, read_col});
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_words.size() > 0 && (quiet || $urandom_range(0, 11) != 0)) begin
        item_valid <= 1'b1;
        kind <= pending_words[0].kind;
        char_code <= pending_words[0].code;
        read_row <= pending_words[0].row;
        read_col <= pending_words[0].col;
        void'(pending_words.pop_front());
      end else begin
        if (pending_words.size() > 0) send_gap <= $urandom_range(0, 14);
        item_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random stall bursts, checks each word against the model.
  // --------------------------------------------------------------------------
  int stall_gap = 0;

  task automatic report(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    console_view_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_views.size() == 0) begin
          report("unexpected result word", 1, 0);
        end else begin
          want = expected_views.pop_front();
          if (read_char !== want.rd_char) report("read_char", read_char, want.rd_char);
          if (read_attr !== want.rd_attr) report("read_attr", read_attr, want.rd_attr);
          if (cursor_row !== want.row) report("cursor_row", cursor_row, want.row);
          if (cursor_col !== want.col) report("cursor_col", cursor_col, want.col);
          if (current_attr !== want.attr) report("current_attr", current_attr, want.attr);
          if (cursor_cell !== want.cell_pos) report("cursor_cell", cursor_cell, want.cell_pos);
          if (escape_active !== want.esc) report("escape_active", escape_active, want.esc);
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_gap <= $urandom_range(0, 14);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any handshake or register access counts as progress.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ansi_text_console_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Phase control and register writes.
  // --------------------------------------------------------------------------
  task automatic drain();
    while (pending_words.size() > 0 || item_valid || expected_views.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write with a setup and an access phase; the model follows once the access edge is past.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      atc_pkg::REG_ROWS: cfg_rows = value & 32'h3F;
      atc_pkg::REG_COLS: cfg_cols = value & 32'hFF;
      default: cfg_attr = value & 32'hFF;
    endcase
    clamp_cursor();
    @(posedge clk);
  endtask

  task automatic set_screen(input int r, input int c, input int a);
    write_reg(atc_pkg::REG_ROWS, r);
    write_reg(atc_pkg::REG_COLS, c);
    write_reg(atc_pkg::REG_ATTR, a);
  endtask

  initial begin
    console_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default 25 by 80 screen: directed words first.
    send_directed();
    send_random_words(70, 1'b0);
    drain();

    // Tiny screen, where wraps and scrolls are frequent and cheap.
    set_screen(3, 8, 8'h5A);
    send_directed();
    send_random_words(90, 1'b0);
    drain();

    // Zero sizes behave as a single cell.
    set_screen(0, 0, 8'h00);
    send_random_words(30, 1'b0);
    drain();

    // Oversized values pin to the largest screen; keep scrolls rare here.
    set_screen(63, 255, 8'hFF);
    send_random_words(45, 1'b1);
    drain();

    // Random small sizes.
    set_screen($urandom_range(1, 8), $urandom_range(1, 24), $urandom_range(0, 255));
    send_random_words(70, 1'b0);
    drain();

    // Back to the default shape with no idling on either side.
    set_screen(25, 80, 8'h17);
    quiet = 1'b1;
    send_random_words(70, 1'b1);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ansi_text_console_top test passed");
    end else begin
      $display("ansi_text_console_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/atc_pkg.sv
rtl/atc_ram.sv
rtl/ansi_text_console_top.sv
test/testbench.sv
